>>> src/cti_pkg.sv
`default_nettype none

package cti_pkg;

	localparam int TABLE_POINTS = 24;

	localparam int MACH_W  = 20;
	localparam int X_W     = 15;
	localparam int DX_W    = 12;
	localparam int Y_W     = 16;
	localparam int SLOPE_W = 20;
	localparam int PROD_W  = 32;
	localparam int SEG_W   = $clog2(TABLE_POINTS - 1);

	localparam logic [X_W-1:0] CLAMP_LO = X_W'(4096);
	localparam logic [X_W-1:0] CLAMP_HI = X_W'(26624);

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

	localparam logic        STATUS_OK  = 1'b0;
	localparam logic        STATUS_NEG = 1'b1;

	// Breakpoints, Q3.12, ascending.
	localparam logic [X_W-1:0] ROM_X [TABLE_POINTS] = '{
		15'd4096,  15'd5017,  15'd5509,  15'd5863,  15'd6154,  15'd6489,
		15'd6785,  15'd7140,  15'd7521,  15'd8105,  15'd8672,  15'd9470,
		15'd10473, 15'd11522, 15'd12934, 15'd14572, 15'd15485, 15'd16614,
		15'd18030, 15'd19748, 15'd21357, 15'd23454, 15'd24963, 15'd26624
	};

	// Coefficient at each breakpoint, Q0.16.
	localparam logic [Y_W-1:0] ROM_Y [TABLE_POINTS] = '{
		16'd22938, 16'd22906, 16'd22493, 16'd21773, 16'd20853, 16'd19624,
		16'd18184, 16'd16820, 16'd15544, 16'd14065, 16'd12745, 16'd11368,
		16'd9889,  16'd8787,  16'd7525,  16'd6337,  16'd5788,  16'd5148,
		16'd4531,  16'd3818,  16'd3335,  16'd2876,  16'd2622,  16'd2405
	};

	// Per-segment slope in coefficient LSBs per argument LSB, scaled by 2^16.
	localparam logic signed [SLOPE_W-1:0] ROM_SLOPE [TABLE_POINTS-1] = '{
		-20'sd2277,   -20'sd55013,  -20'sd133294, -20'sd207193, -20'sd240429,
		-20'sd318824, -20'sd251806, -20'sd219485, -20'sd165972, -20'sd152571,
		-20'sd113087, -20'sd96638,  -20'sd68847,  -20'sd58574,  -20'sd47532,
		-20'sd39408,  -20'sd37151,  -20'sd28556,  -20'sd27199,  -20'sd19673,
		-20'sd14345,  -20'sd11031,  -20'sd8562
	};

	typedef struct packed {
		logic             neg;
		logic [X_W-1:0]   x;
		logic [SEG_W-1:0] seg;
	} seg_info_t;

	typedef struct packed {
		logic [X_W-1:0]            x;
		logic [Y_W-1:0]            y;
		logic signed [SLOPE_W-1:0] slope;
	} rom_entry_t;

endpackage

`default_nettype wire

>>> src/clamped_table_interpolator.sv
// Clamped piecewise-linear table interpolator.
//
// Input channel: in_valid / in_stall carry one beat per argument on mach,
// a signed Q8.12 value. Output channel: out_valid / out_stall carry one
// beat per result, coeff (unsigned Q0.16) and status (1 when the argument
// was negative, in which case coeff is 0).
//
// The path has four register stages. The block takes one beat per cycle
// while the receiver does not stall: stage one clamps and finds the
// segment by parallel breakpoint compares, stage two reads the coefficient
// ROM, stage three does the one multiply, and stage four rounds, saturates
// and holds the output register.
//
// Reset clears all stage valid bits; there is no table state to restore.
// When the receiver stalls, the result holds in the output register and
// empty stages behind it keep filling; in_stall rises only once all four
// stages hold a beat.
`default_nettype none

module clamped_table_interpolator
	import cti_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [MACH_W-1:0] mach,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [Y_W-1:0]         coeff,
	output logic                   status
);

	logic       v_s1_q;
	logic       v_s2_q;
	logic       v_s3_q;
	logic       out_valid_q;
	logic       en_s1;
	logic       en_s2;
	logic       en_s3;
	logic       en_out;
	seg_info_t  info;
	seg_info_t  info_s1;
	logic [X_W-1:0] x_s2;
	logic       neg_s2;
	rom_entry_t entry;

	// A stage loads when it is empty or its successor loads, so bubbles
	// collapse while the output is stalled.
	assign en_out   = ~out_valid_q | ~out_stall;
	assign en_s3    = ~v_s3_q | en_out;
	assign en_s2    = ~v_s2_q | en_s3;
	assign en_s1    = ~v_s1_q | en_s2;
	assign in_stall = ~en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			v_s3_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) v_s1_q <= in_valid;
			if (en_s2) v_s2_q <= v_s1_q;
			if (en_s3) v_s3_q <= v_s2_q;
			if (en_out) out_valid_q <= v_s3_q;
		end
	end

	cti_seg_find u_seg_find (
		.mach (mach),
		.info (info)
	);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			info_s1 <= info;
		end
	end

	// The ROM output register is the second pipeline stage.
	cti_rom u_rom (
		.clk  (clk),
		.en   (en_s2),
		.addr (info_s1.seg),
		.rd_q (entry)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			x_s2   <= info_s1.x;
			neg_s2 <= info_s1.neg;
		end
	end

	cti_interp u_interp (
		.clk      (clk),
		.en_s3    (en_s3),
		.en_out   (en_out),
		.neg_s2   (neg_s2),
		.x_s2     (x_s2),
		.entry    (entry),
		.coeff_q  (coeff),
		.status_q (status)
	);

	assign out_valid = out_valid_q;

	// An error result always carries a zero coefficient.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_NEG) |-> coeff == '0)
		else $error("negative-argument result with nonzero coefficient");

	// The input side stalls only when every stage holds a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1_q && v_s2_q && v_s3_q && out_valid_q)
		else $error("input stalled while a pipeline stage is empty");

	// The segment index never passes the last segment.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q |-> info_s1.seg <= SEG_W'(TABLE_POINTS - 2))
		else $error("segment index out of range");

	// A beat in stage three reaches the output once it is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3_q && en_out |=> out_valid_q)
		else $error("beat lost between multiply stage and output");

endmodule

`default_nettype wire

>>> src/cti_seg_find.sv
`default_nettype none

module cti_seg_find
	import cti_pkg::*;
(
	input  wire logic [MACH_W-1:0] mach,
	output seg_info_t              info
);

	logic [X_W-1:0]          x_clamped;
	logic [TABLE_POINTS-1:0] ge;
	logic [TABLE_POINTS-1:0] hit;
	logic [SEG_W-1:0]        seg;

	always_comb begin
		if (mach[MACH_W-2:0] < (MACH_W-1)'(CLAMP_LO)) begin
			x_clamped = CLAMP_LO;
		end else if (mach[MACH_W-2:0] > (MACH_W-1)'(CLAMP_HI)) begin
			x_clamped = CLAMP_HI;
		end else begin
			x_clamped = mach[X_W-1:0];
		end
	end

	// Thermometer of breakpoint compares; the first compare is forced high,
	// and the last breakpoint never starts a segment of its own.
	always_comb begin
		ge = '0;
		ge[0] = 1'b1;
		for (int i = 1; i < TABLE_POINTS - 1; i++) begin
			ge[i] = (x_clamped >= ROM_X[i]);
		end
	end

	always_comb begin
		seg = '0;
		for (int i = 0; i < TABLE_POINTS; i++) begin
			hit[i] = ge[i] & ((i == TABLE_POINTS - 1) ? 1'b1 : ~ge[(i + 1) % TABLE_POINTS]);
			if (hit[i]) begin
				seg = seg | SEG_W'(i);
			end
		end
	end

	assign info.neg = mach[MACH_W-1];
	assign info.x   = x_clamped;
	assign info.seg = seg;

endmodule

`default_nettype wire

>>> src/cti_rom.sv
`default_nettype none

module cti_rom
	import cti_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [SEG_W-1:0] addr,
	output rom_entry_t            rd_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			rd_q.x     <= ROM_X[addr];
			rd_q.y     <= ROM_Y[addr];
			rd_q.slope <= ROM_SLOPE[addr];
		end
	end

endmodule

`default_nettype wire

>>> src/cti_interp.sv
`default_nettype none

module cti_interp
	import cti_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           en_s3,
	input  wire logic           en_out,
	input  wire logic           neg_s2,
	input  wire logic [X_W-1:0] x_s2,
	input  rom_entry_t          entry,
	output logic [Y_W-1:0]      coeff_q,
	output logic                status_q
);

	logic [X_W-1:0]              dx_full;
	logic [DX_W-1:0]             dx;
	logic signed [DX_W+SLOPE_W:0] prod;
	logic signed [PROD_W-1:0]    prod_s3;
	logic [Y_W-1:0]              y_s3;
	logic                        neg_s3;
	logic [PROD_W-1:0]           t;
	logic signed [Y_W+1:0]       y_sum;
	logic [Y_W-1:0]              y_sat;

	assign dx_full = x_s2 - entry.x;
	assign dx      = dx_full[DX_W-1:0];
	assign prod    = $signed({1'b0, dx}) * entry.slope;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3 <= prod[PROD_W-1:0];
			y_s3    <= entry.y;
			neg_s3  <= neg_s2;
		end
	end

	// Round to nearest by adding one half, then floor via the upper half.
	always_comb begin
		t     = prod_s3 + ROUND_HALF;
		y_sum = $signed({2'b00, y_s3}) + $signed({{2{t[PROD_W-1]}}, t[PROD_W-1:Y_W]});
		if (y_sum[Y_W+1]) begin
			y_sat = '0;
		end else if (y_sum[Y_W]) begin
			y_sat = '1;
		end else begin
			y_sat = y_sum[Y_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			coeff_q  <= neg_s3 ? '0 : y_sat;
			status_q <= neg_s3 ? STATUS_NEG : STATUS_OK;
		end
	end

endmodule

`default_nettype wire

>>> tb/clamped_table_interpolator_test.sv
`timescale 1ns / 100ps

module clamped_table_interpolator_test;
	import cti_pkg::*;

	// The run ends with a failure if it is still going after this many cycles.
	// The slowest correct run is about 1700 beats. Each beat can take a send
	// gap, a receive stall and the pipeline fill, and even so this limit
	// leaves a wide margin.
	localparam int CYCLE_LIMIT = 400000;

	// Cycles to wait after the last result, longer than the four-stage pipeline takes to drain.
	localparam int DRAIN_CYCLES = 20;

	localparam int MAX_REPORTS = 10;

	// Clamp span of the argument in Q8.12: 1.0 and 6.5.
	localparam longint SPAN_LO = 4096;
	localparam longint SPAN_HI = 26624;

	// Breakpoints and coefficients as five-decimal values, scaled by 1e5.
	// They are converted to fixed point at the start of the run, so the
	// predictor does not lean on the ROM contents in the package.
	localparam longint DEC_X [TABLE_POINTS] = '{
		100000, 122476, 134501, 143137, 150234, 158419,
		165661, 174312, 183606, 197887, 211715, 231210,
		255691, 281306, 315762, 355753, 378043, 405623,
		440192, 482128, 521420, 572612, 609448, 650000
	};
	localparam longint DEC_Y [TABLE_POINTS] = '{
		35000, 34952, 34322, 33223, 31819, 29944,
		27747, 25666, 23719, 21462, 19448, 17346,
		15089, 13408, 11483, 9670,  8832,  7855,
		6914,  5826,  5089,  4388,  4001,  3669
	};

	typedef struct {
		logic [MACH_W-1:0] arg;
		logic [Y_W-1:0]    coeff;
		logic              status;
	} coeff_beat_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [MACH_W-1:0] mach      = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [Y_W-1:0]    coeff;
	logic              status;

	// Fixed-point copy of the table, filled in at time zero.
	longint breakpoint_x [TABLE_POINTS];
	longint coeff_at     [TABLE_POINTS];
	longint slope_of     [TABLE_POINTS-1];

	// Predicted results, oldest first, waiting for their output beat.
	coeff_beat_t pending_coeffs [$];

	int mismatches  = 0;
	int cycle_count = 0;

	// The sender and the receiver each alternate between stretches of random
	// idling and stretches with no idling at all.
	int send_stretch_left = 0;
	bit send_busy         = 0;
	int recv_stretch_left = 0;
	bit recv_busy         = 0;
	int recv_hold         = 0;

	clamped_table_interpolator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mach      (mach),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.coeff     (coeff),
		.status    (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, pending_coeffs.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// The breakpoints and values are rounded half up from their decimal
	// form. Each slope is the rise over the run in Q.16, rounded half away
	// from zero. A zero-width segment gets a flat slope.
	task automatic build_table();
		longint run, rise, mag, q;
		for (int i = 0; i < TABLE_POINTS; i++) begin
			breakpoint_x[i] = (DEC_X[i] * 4096 + 50000) / 100000;
			coeff_at[i]     = (DEC_Y[i] * 65536 + 50000) / 100000;
		end
		for (int i = 0; i < TABLE_POINTS - 1; i++) begin
			run  = breakpoint_x[i+1] - breakpoint_x[i];
			rise = (coeff_at[i+1] - coeff_at[i]) * 65536;
			if (run <= 0) begin
				slope_of[i] = 0;
			end else begin
				mag = (rise < 0) ? -rise : rise;
				q   = (mag + run / 2) / run;
				slope_of[i] = (rise < 0) ? -q : q;
			end
		end
	endtask

	function automatic coeff_beat_t predict_coeff(input logic [MACH_W-1:0] raw);
		coeff_beat_t r;
		longint x, dx, t, frac, y;
		int seg;
		r.arg = raw;
		x = raw;
		if (raw[MACH_W-1])
			x -= (longint'(1) << MACH_W);
		if (x < 0) begin
			r.coeff  = '0;
			r.status = STATUS_NEG;
			return r;
		end
		if (x < SPAN_LO)
			x = SPAN_LO;
		else if (x > SPAN_HI)
			x = SPAN_HI;
		// An argument on a breakpoint starts that breakpoint's segment.
		// The last breakpoint still falls in the last segment.
		seg = 0;
		for (int i = 1; i < TABLE_POINTS - 1; i++)
			if (x >= breakpoint_x[i])
				seg = i;
		dx = x - breakpoint_x[seg];
		t  = dx * slope_of[seg] + 32768;
		// Floor division, so that negative products round toward minus infinity.
		if (t >= 0)
			frac = t / 65536;
		else
			frac = -((-t + 65535) / 65536);
		y = coeff_at[seg] + frac;
		if (y < 0)
			y = 0;
		else if (y > 65535)
			y = 65535;
		r.coeff  = y[Y_W-1:0];
		r.status = STATUS_OK;
		return r;
	endfunction

	// Sends one argument beat. The task starts and ends just after a rising
	// edge. in_valid stays high when there is no gap before the next beat, so
	// back-to-back beats never see valid lowered and raised in one time step.
	task automatic send_mach(input logic [MACH_W-1:0] value);
		int gap;
		if (send_stretch_left == 0) begin
			send_stretch_left = $urandom_range(20, 80);
			send_busy = ($urandom_range(0, 2) != 0);
		end
		send_stretch_left--;
		gap = send_busy ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mach     <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_coeffs.push_back(predict_coeff(value));
	endtask

	// Checks each output beat against the oldest prediction and drives the
	// receiver's stall. The values read here are the ones from before the
	// edge, because the block and the testbench both update with
	// nonblocking assignments.
	always @(posedge clk) begin
		coeff_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_coeffs.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: coeff %0d status %0d",
							coeff, status);
				end else begin
					want = pending_coeffs.pop_front();
					if (coeff !== want.coeff || status !== want.status) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mach 0x%05h: want %0d/%0d, got %0d/%0d",
								want.arg, want.coeff, want.status,
								coeff, status);
					end
				end
				if (recv_stretch_left == 0) begin
					recv_stretch_left = $urandom_range(20, 80);
					recv_busy = ($urandom_range(0, 2) != 0);
				end
				recv_stretch_left--;
				recv_hold = recv_busy ? $urandom_range(0, 10) : 0;
			end else if (recv_hold > 0) begin
				recv_hold--;
			end
			out_stall <= (recv_hold > 0);
		end
	end

	// Field extremes and each edge of the clamp span. Also covers the region
	// below 1.0 and the region past 6.5, and a few points on and next to
	// breakpoints, the last breakpoint among them.
	task automatic test_directed();
		int args [20] = '{
			-524288, -4096, -1, 0, 1, 2048, 4095, 4096, 4097,
			5016, 5017, 5018, 12934, 24962, 24963, 26623, 26624,
			26625, 40000, 524287
		};
		foreach (args[i])
			send_mach(MACH_W'(args[i]));
	endtask

	// Arguments on each breakpoint and a couple of LSBs to either side.
	// These test the segment choice and the rounding at segment ends.
	task automatic test_breakpoints();
		int idx, off;
		repeat (240) begin
			idx = $urandom_range(0, TABLE_POINTS - 1);
			off = int'($urandom_range(0, 4)) - 2;
			send_mach(MACH_W'(breakpoint_x[idx] + off));
		end
	endtask

	// Random arguments, mostly inside the span and just around it. Now and
	// then one is below 1.0 or negative.
	task automatic test_table_span();
		int pick;
		repeat (950) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				send_mach(MACH_W'(-int'($urandom_range(1, 8192))));
			else if (pick == 1)
				send_mach(MACH_W'($urandom_range(0, 4096)));
			else
				send_mach(MACH_W'($urandom_range(4000, 28672)));
		end
	endtask

	// Arguments drawn over the full 20-bit field, so that every bit of mach
	// takes both values. Half of them are negative and most of the rest are
	// clamped to the top.
	task automatic test_full_range();
		repeat (500)
			send_mach(MACH_W'($urandom()));
	endtask

	initial begin
		build_table();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_directed();
		test_breakpoints();
		test_table_span();
		test_full_range();
		in_valid <= 1'b0;

		while (pending_coeffs.size() != 0)
			@(posedge clk);
		// Any extra result that shows up during this wait has no prediction
		// and counts as a mismatch.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
